// ===== src/hpe_pkg.sv =====
// shared types, code tables and queue entry format for the hpack huffman encoder
package hpe_pkg;

  localparam int unsigned CodeMaxLen  = 30;
  localparam int unsigned AccWidth    = 40;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = 2;

  typedef logic [4:0]  code_len_t;
  typedef logic [29:0] code_val_t;
  typedef code_len_t   len_tab_t [256];
  typedef code_val_t   val_tab_t [256];

  localparam len_tab_t CODE_LEN = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
  };

  // canonical code: within each length, codes follow symbol order
  function automatic val_tab_t build_codes();
    val_tab_t    tab;
    logic [31:0] code;
    code = '0;
    for (int len = 1; len <= CodeMaxLen; len++) begin
      for (int s = 0; s < 256; s++) begin
        if (int'(CODE_LEN[s]) == len) begin
          tab[s] = code[29:0];
          code   = code + 32'd1;
        end
      end
      code = code << 1;
    end
    return tab;
  endfunction

  localparam val_tab_t CODE_VAL = build_codes();

  // one queued piece of work: up to five bytes, left aligned, then an optional fallback
  typedef struct packed {
    logic [AccWidth-1:0] data;
    logic [2:0]          ndata;
    logic                fail;
    logic                last;
  } work_t;

endpackage

// ===== src/hpe_front.sv =====
// front end: code lookup, bit packing and length check per input byte
module hpe_front import hpe_pkg::*; #(
  parameter int unsigned MAX_LEN_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              sym_i,
  input  logic [MAX_LEN_BITS-1:0] total_len_i,
  input  logic                    last_i,
  output logic                    push_o,
  output work_t                   work_o
);

  logic [6:0]              res_bits_q, res_bits_d;
  logic [2:0]              res_cnt_q, res_cnt_d;
  logic [MAX_LEN_BITS-1:0] emitted_q, emitted_d;
  logic                    disc_q, disc_d;

  logic [4:0]              nb;
  logic [AccWidth-1:0]     acc;
  logic [5:0]              cnt;
  logic [AccWidth-1:0]     packed_bits;
  logic [2:0]              full;
  logic [2:0]              rem;
  logic [2:0]              k;
  logic [MAX_LEN_BITS-1:0] j0;
  logic                    fail;
  logic [2:0]              ndata;
  logic [6:0]              rem_mask;

  always_comb begin
    nb          = CODE_LEN[sym_i];
    acc         = ({{(AccWidth-7){1'b0}}, res_bits_q} << nb)
                | {{(AccWidth-30){1'b0}}, CODE_VAL[sym_i]};
    cnt         = {3'd0, res_cnt_q} + {1'b0, nb};
    full        = cnt[5:3];
    rem         = cnt[2:0];
    k           = full + {2'd0, (last_i && (rem != 3'd0))};
    // left align, pad with ones below the code bits
    packed_bits = (acc << (6'(AccWidth) - cnt)) | ({AccWidth{1'b1}} >> cnt);
    rem_mask    = 7'((8'd1 << rem) - 8'd1);
    j0          = total_len_i - emitted_q;
    if (total_len_i == '0) begin
      fail  = 1'b1;
      ndata = 3'd0;
    end else if ((j0 != '0) && (j0 <= MAX_LEN_BITS'(k))) begin
      fail  = 1'b1;
      ndata = 3'(j0 - MAX_LEN_BITS'(1));
    end else begin
      fail  = 1'b0;
      ndata = k;
    end
  end

  always_comb begin
    res_bits_d = res_bits_q;
    res_cnt_d  = res_cnt_q;
    emitted_d  = emitted_q;
    disc_d     = disc_q;
    push_o     = 1'b0;
    if (accept_i) begin
      if (disc_q) begin
        if (last_i) disc_d = 1'b0;
      end else begin
        push_o = fail || (ndata != 3'd0);
        if (fail || last_i) begin
          res_bits_d = '0;
          res_cnt_d  = '0;
          emitted_d  = '0;
          disc_d     = fail && !last_i;
        end else begin
          res_bits_d = acc[6:0] & rem_mask;
          res_cnt_d  = rem;
          emitted_d  = emitted_q + MAX_LEN_BITS'(full);
        end
      end
    end
  end

  assign work_o.data  = packed_bits;
  assign work_o.ndata = ndata;
  assign work_o.fail  = fail;
  assign work_o.last  = last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q <= '0;
      res_cnt_q  <= '0;
      emitted_q  <= '0;
      disc_q     <= 1'b0;
    end else begin
      res_bits_q <= res_bits_d;
      res_cnt_q  <= res_cnt_d;
      emitted_q  <= emitted_d;
      disc_q     <= disc_d;
    end
  end

endmodule

// ===== src/hpe_fifo.sv =====
// small work queue between front end and byte emitter
module hpe_fifo import hpe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t wdata_i,
  input  logic  pop_i,
  output work_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);

  work_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueuePtrW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end

endmodule

// ===== src/hpe_back.sv =====
// back end: serializes queued work into one result per cycle while the receiver is ready
module hpe_back import hpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  work_t      head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_status_o,
  output logic       out_last_o
);

  logic [AccWidth-1:0] data_q, data_d;
  logic [2:0]          ndata_q, ndata_d;
  logic                fail_q, fail_d;
  logic                last_q, last_d;
  logic                ov_q;
  logic [7:0]          ob_q;
  logic                os_q, ol_q;

  logic work_has, can_emit, emit, final_one;
  logic [7:0] nbyte;
  logic nstat, nlast;

  always_comb begin
    work_has  = (ndata_q != 3'd0) || fail_q;
    can_emit  = !ov_q || out_ready_i;
    emit      = can_emit && work_has;
    final_one = (ndata_q == 3'd1 && !fail_q) || (ndata_q == 3'd0);
    if (ndata_q != 3'd0) begin
      nbyte = data_q[AccWidth-1 -: 8];
      nstat = 1'b0;
      nlast = !fail_q && last_q && (ndata_q == 3'd1);
    end else begin
      nbyte = 8'd0;
      nstat = 1'b1;
      nlast = 1'b1;
    end
    pop_o   = !empty_i && (!work_has || (emit && final_one));
    data_d  = data_q;
    ndata_d = ndata_q;
    fail_d  = fail_q;
    last_d  = last_q;
    if (emit) begin
      if (ndata_q != 3'd0) begin
        data_d  = data_q << 8;
        ndata_d = ndata_q - 3'd1;
      end else begin
        fail_d = 1'b0;
      end
    end
    if (pop_o) begin
      data_d  = head_i.data;
      ndata_d = head_i.ndata;
      fail_d  = head_i.fail;
      last_d  = head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndata_q <= '0;
      fail_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      ndata_q <= ndata_d;
      fail_q  <= fail_d;
      if (emit)             ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    if (emit) begin
      ob_q <= nbyte;
      os_q <= nstat;
      ol_q <= nlast;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign out_status_o = os_q;
  assign out_last_o   = ol_q;

endmodule

// ===== src/hpack_huffman_encoder.sv =====
// top level of the hpack string huffman encoder
// Input stream (s_axis): one string octet per transaction, with the total
// string length in tdata and tlast on the final octet. Output stream (m_axis):
// one encoded octet per transaction, tuser high for the fallback status that
// says the encoding is not shorter and the string should be sent raw; tlast
// marks the final result of a string. After a fallback the rest of the string
// is dropped up to its tlast.
// Throughput: one input octet per cycle while the work queue has room; the
// emitter sends one result per cycle while the receiver is ready, so an octet
// whose code spans k output bytes occupies the emitter for k results and a
// long code run fills the four-entry queue, after which s_axis_tready drops.
// The first result of an octet passes the queue, the emitter registers and
// the output register before it is valid.
// Reset clears the residual bits, byte count, discard flag and queue; the
// block is ready in the first cycle after reset. A stalled receiver holds the
// output register; the queue keeps taking input until it is full.
module hpack_huffman_encoder import hpe_pkg::*; #(
  parameter int unsigned MAX_LEN_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] in_byte, [MAX_LEN_BITS+7:8] total_length, rest zero
  input  logic [((8 + MAX_LEN_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]            m_axis_tdata,
  // [0] out_status
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic  accept, push, pop, empty, full;
  work_t work, head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hpe_front #(.MAX_LEN_BITS(MAX_LEN_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .sym_i       (s_axis_tdata[7:0]),
    .total_len_i (s_axis_tdata[MAX_LEN_BITS+7:8]),
    .last_i      (s_axis_tlast),
    .push_o      (push),
    .work_o      (work)
  );

  hpe_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (work),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  hpe_back u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  a_fallback_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("fallback result without last");

  a_fallback_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("fallback result with nonzero data");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the hpack huffman encoder stream block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] octet;
    logic       status;
    logic       last;
  } enc_result_t;

  // tracks the encoder state and the encoded octets still owed by the block
  class enc_scoreboard;
    logic [29:0]  code_tab[256];
    logic [6:0]   pend_bits;
    logic [2:0]   pend_cnt;
    logic [11:0]  sent_cnt;
    logic         skipping;
    enc_result_t  owed[$];
    int           errors;

    function new();
      logic [31:0] code;
      code = '0;
      for (int len = 1; len <= 30; len++) begin
        for (int s = 0; s < 256; s++) begin
          if (int'(hpe_pkg::CODE_LEN[s]) == len) begin
            code_tab[s] = code[29:0];
            code = code + 1;
          end
        end
        code = code << 1;
      end
      pend_bits = '0;
      pend_cnt  = '0;
      sent_cnt  = '0;
      skipping  = 1'b0;
      errors    = 0;
    endfunction

    function void owe(logic [7:0] octet, logic status, logic last);
      enc_result_t r;
      r.octet  = octet;
      r.status = status;
      r.last   = last;
      owed.push_back(r);
    endfunction

    function void fall_back(logic last);
      owe(8'h00, 1'b1, 1'b1);
      pend_bits = '0;
      pend_cnt  = '0;
      sent_cnt  = '0;
      skipping  = !last;
    endfunction

    function void note_octet(logic [7:0] sym, logic [11:0] tl, logic last);
      logic [39:0] acc;
      int          nb;
      int          cnt;
      int          n;
      logic [7:0]  octet;
      int          fill;
      n = 0;
      if (skipping) begin
        if (last) begin
          skipping  = 1'b0;
          pend_bits = '0;
          pend_cnt  = '0;
          sent_cnt  = '0;
        end
        return;
      end
      if (tl == 0) begin
        fall_back(last);
        return;
      end
      nb  = int'(hpe_pkg::CODE_LEN[sym]);
      acc = (40'(pend_bits) << nb) | 40'(code_tab[sym]);
      cnt = int'(pend_cnt) + nb;
      while (cnt >= 8) begin
        cnt   = cnt - 8;
        octet = 8'(acc >> cnt);
        if (sent_cnt + 12'd1 == tl) begin
          fall_back(last);
          return;
        end
        owe(octet, 1'b0, 1'b0);
        n++;
        sent_cnt = sent_cnt + 12'd1;
      end
      acc = acc & ((40'd1 << cnt) - 40'd1);
      if (!last) begin
        pend_bits = 7'(acc);
        pend_cnt  = 3'(cnt);
        return;
      end
      if (cnt > 0) begin
        fill  = 8 - cnt;
        octet = 8'((acc << fill) | ((40'd1 << fill) - 40'd1));
        if (sent_cnt + 12'd1 == tl) begin
          fall_back(last);
          return;
        end
        owe(octet, 1'b0, 1'b0);
        n++;
      end
      if (n > 0) owed[$].last = 1'b1;
      pend_bits = '0;
      pend_cnt  = '0;
      sent_cnt  = '0;
    endfunction

    function void check_result(logic [7:0] octet, logic status, logic last);
      enc_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result octet=%h status=%b last=%b", octet, status, last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (status !== e.status) begin
        $error("out_status expected %b actual %b", e.status, status);
        errors++;
      end
      // the octet carries no meaning in a fallback result
      if (!e.status && octet !== e.octet) begin
        $error("out_byte expected %h actual %h", e.octet, octet);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_last expected %b actual %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  enc_scoreboard enc_sb = new();
  int src_idle = 36;
  int sink_idle = 50;
  int sink_cycles = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;

  hpack_huffman_encoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver with random stalls and one long hold-off to fill the queue
  always @(negedge clk_i) begin
    sink_cycles <= sink_cycles + 1;
    if (sink_cycles == 300) sink_hold <= 400;
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      enc_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("hpack_huffman_encoder: mismatch");
        $finish;
      end
    end
  end

  task automatic send_octet(logic [7:0] sym, logic [11:0] tl, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, tl, sym};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    enc_sb.note_octet(sym, tl, last);
  endtask

  // mostly printable text with short codes, plus any octet now and then
  task automatic send_string();
    int          n;
    logic [11:0] tl;
    logic [7:0]  sym;
    n  = $urandom_range(1, 8);
    tl = ($urandom_range(99) < 85) ? 12'(n) : 12'($urandom_range(0, 4095));
    for (int k = 0; k < n; k++) begin
      sym = ($urandom_range(99) < 75) ? 8'($urandom_range(32, 126)) : 8'($urandom);
      send_octet(sym, tl, (k == n - 1) && ($urandom_range(99) < 95));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, fallback, pad, zero length and discard
    send_octet(8'h00, 12'd4095, 1'b1);
    send_octet(8'hff, 12'd4095, 1'b1);
    send_octet(8'h61, 12'd1, 1'b1);
    send_octet(8'h30, 12'd2, 1'b0);
    send_octet(8'h31, 12'd2, 1'b1);
    send_octet(8'h77, 12'd3, 1'b0);
    send_octet(8'h77, 12'd3, 1'b0);
    send_octet(8'h77, 12'd3, 1'b1);
    send_octet(8'h41, 12'd0, 1'b1);
    send_octet(8'h0a, 12'd3, 1'b0);
    send_octet(8'h41, 12'd3, 1'b0);
    send_octet(8'h42, 12'd3, 1'b1);
    send_octet(8'h16, 12'd2048, 1'b0);
    send_octet(8'h0d, 12'd2048, 1'b0);
    send_octet(8'h0a, 12'd2048, 1'b1);
    send_octet(8'h65, 12'd4095, 1'b0);
    send_octet(8'h80, 12'd4095, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle  = (ph == 0) ? 36 : (ph == 1) ? 50 : 0;
      sink_idle = (ph == 0) ? 50 : (ph == 1) ? 36 : 0;
      for (int i = 0; i < 36; i++) send_string();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (enc_sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (enc_sb.errors == 0 && enc_sb.owed.size() == 0) begin
      $display("hpack_huffman_encoder: match");
    end else begin
      $display("hpack_huffman_encoder: mismatch");
    end
    $finish;
  end

endmodule
